/* hw/rtl/text_glyph_cell_renderer_macros.svh */
// Assertion macros for the checker file of the glyph renderer.
// Both macros expect signals named clock and reset in the scope where they are used.
`ifndef TEXT_GLYPH_CELL_RENDERER_MACROS_SVH
`define TEXT_GLYPH_CELL_RENDERER_MACROS_SVH

// A property that must hold in every cycle outside reset.
`define TGCR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition in one cycle implies a consequence in the next cycle.
`define TGCR_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/tgcr_pkg.sv */
package tgcr_pkg;

   // Coordinate and glyph geometry.
   localparam int COORD_BITS = 12;
   localparam int OUT_BITS = 13;
   localparam int GLYPH_COUNT = 95;
   localparam int GLYPH_COLS = 5;
   localparam int CELL_COLS = 6;
   localparam int GLYPH_ROWS = 8;
   localparam int ROW_BITS = $clog2(GLYPH_ROWS);
   localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
   localparam int WALK_STEPS = CELL_COLS * GLYPH_ROWS;
   localparam int STEP_BITS = $clog2(WALK_STEPS);
   localparam logic [11:0] COORD_MAX = 12'((1 << COORD_BITS) - 1);

   // Operation codes of the request channel.
   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_CURSOR = 1'b1;

   // Character codes with special handling.
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_FIRST = 8'h20;
   localparam logic [7:0] CHAR_LAST = 8'h7E;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;

   // Configuration register indexes.
   localparam logic [2:0] CSR_FG_COLOR = 3'd0;
   localparam logic [2:0] CSR_BG_COLOR = 3'd1;
   localparam logic [2:0] CSR_OPAQUE_MODE = 3'd2;
   localparam logic [2:0] CSR_TEXT_SIZE = 3'd3;
   localparam logic [2:0] CSR_WRAP_ENABLE = 3'd4;
   localparam logic [2:0] CSR_DISPLAY_WIDTH = 3'd5;

   // Font bitmaps, column-major: bits [7:0] hold column 0 with bit 0 as the top row.
   localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h122A7F2A24,
      40'h6264081323, 40'h5022554936, 40'h0000030500, 40'h0041221C00, 40'h001C224100,
      40'h14083E0814, 40'h08083E0808, 40'h0000305000, 40'h0808080808, 40'h0000606000,
      40'h0204081020, 40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
      40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101, 40'h3649494936,
      40'h1E29494906, 40'h0000363600, 40'h0000365600, 40'h4122140800, 40'h1414141414,
      40'h0008142241, 40'h0609510102, 40'h3E41794932, 40'h7E1111117E, 40'h364949497F,
      40'h224141413E, 40'h1C2241417F, 40'h414949497F, 40'h010109097F, 40'h325141413E,
      40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
      40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E, 40'h060909097F, 40'h5E2151413E,
      40'h462919097F, 40'h3149494946, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h4345495161, 40'h41417F0000,
      40'h2010080402, 40'h00007F4141, 40'h0402010204, 40'h4040404040, 40'h0004020100,
      40'h7854545420, 40'h384444487F, 40'h2044444438, 40'h7F48444438, 40'h1854545438,
      40'h0201097E08, 40'h3C54541408, 40'h780404087F, 40'h00407D4400, 40'h003D444020,
      40'h004428107F, 40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
      40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448, 40'h2040443F04,
      40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h3C5050500C,
      40'h444C546444, 40'h0041360800, 40'h00007F0000, 40'h0008364100, 40'h0810080408
   };

   // Start of one glyph walk: the bitmap and the top-left corner of the glyph.
   typedef struct packed {
      logic [GLYPH_BITS-1:0] glyph;
      logic [11:0] x;
      logic [11:0] y;
   } walk_start_type;

   // The cell position the walker currently points at.
   typedef struct packed {
      logic emit;
      logic lit;
      logic last;
      logic [OUT_BITS-1:0] x;
      logic [OUT_BITS-1:0] y;
   } cell_type;

   // Clamp a coordinate sum to the cursor range.
   function automatic logic [11:0] sat_coord(input logic [OUT_BITS-1:0] value);
      return (value > OUT_BITS'(COORD_MAX)) ? COORD_MAX : value[11:0];
   endfunction

endpackage

/* hw/rtl/tgcr_glyph_walker.sv */
// Walks the 6 by 8 cell positions of one glyph, one position per step. The bitmap sits
// in a shift register that drops one bit per step, and the cell corner is kept by two
// small accumulators, so each step costs a shift and one narrow add.
module tgcr_glyph_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tgcr_pkg::walk_start_type start_data,
   input  logic [3:0]               size,
   input  logic                     opaque,
   input  logic                     advance,
   output logic                     busy,
   output tgcr_pkg::cell_type       walk_cell
);

   logic                                busy_ff, busy_in;
   logic [tgcr_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [tgcr_pkg::GLYPH_BITS-1:0]     glyph_ff, glyph_in;
   logic [tgcr_pkg::OUT_BITS-1:0]       x_ff, x_in;
   logic [tgcr_pkg::OUT_BITS-1:0]       y_ff, y_in;
   logic [11:0]                         base_y_ff, base_y_in;
   logic                                step_done;
   logic                                row_end;

   assign step_done = (step_ff == tgcr_pkg::STEP_BITS'(tgcr_pkg::WALK_STEPS - 1));
   assign row_end = (step_ff[tgcr_pkg::ROW_BITS-1:0] ==
                     tgcr_pkg::ROW_BITS'(tgcr_pkg::GLYPH_ROWS - 1));

   // Load a new glyph on start, otherwise shift one cell position per advance.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      glyph_in = glyph_ff;
      x_in = x_ff;
      y_in = y_ff;
      base_y_in = base_y_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         glyph_in = start_data.glyph;
         x_in = tgcr_pkg::OUT_BITS'(start_data.x);
         y_in = tgcr_pkg::OUT_BITS'(start_data.y);
         base_y_in = start_data.y;
      end else if (busy_ff && advance) begin
         glyph_in = {1'b0, glyph_ff[tgcr_pkg::GLYPH_BITS-1:1]};
         step_in = step_ff + 1'b1;
         if (row_end) begin
            x_in = x_ff + tgcr_pkg::OUT_BITS'(size);
            y_in = tgcr_pkg::OUT_BITS'(base_y_ff);
         end else begin
            y_in = y_ff + tgcr_pkg::OUT_BITS'(size);
         end
         if (step_done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      x_ff <= x_in;
      y_ff <= y_in;
      base_y_ff <= base_y_in;
   end

   // In transparent mode the last cell is the lit one with nothing lit after it.
   always_comb begin
      walk_cell.lit = glyph_ff[0];
      walk_cell.emit = busy_ff && (glyph_ff[0] || opaque);
      walk_cell.last = opaque ? step_done
                              : (glyph_ff[0] && (glyph_ff[tgcr_pkg::GLYPH_BITS-1:1] == '0));
      walk_cell.x = x_ff;
      walk_cell.y = y_ff;
   end

   assign busy = busy_ff;

endmodule

/* hw/rtl/text_glyph_cell_renderer.sv */
// Text cursor and 5x7 glyph expander. A request either sets the cursor (op 1) or writes a
// character byte (op 0). Carriage return is ignored, newline moves to column 0 and down
// 8*text_size pixels, and other codes outside 0x20..0x7E are drawn as '?'. A character
// wraps first when wrap_enable is set and the glyph would pass display_width, then emits
// its 6 by 8 cells column by column, top row first, each as one response transaction
// with the cell's top-left corner and color; in transparent mode only lit cells appear,
// and last_cell marks the final cell of the character. A cursor set, carriage return or
// newline does not occupy the block. A character holds off further requests while the
// glyph walker steps through one cell position per cycle, stalling only while a
// finished cell waits on rsp_ready. The cursor saturates at 4095. Configuration writes
// take effect at once and belong in idle periods.
module text_glyph_cell_renderer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_char_code,
   input  logic [11:0] req_new_x,
   input  logic [11:0] req_new_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [12:0] rsp_cell_x,
   output logic [12:0] rsp_cell_y,
   output logic [15:0] rsp_cell_color,
   output logic        rsp_last_cell,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] fg_color_ff, fg_color_in;
   logic [15:0] bg_color_ff, bg_color_in;
   logic        opaque_mode_ff, opaque_mode_in;
   logic [3:0]  text_size_ff, text_size_in;
   logic        wrap_enable_ff, wrap_enable_in;
   logic [11:0] display_width_ff, display_width_in;
   logic [11:0] cursor_x_ff, cursor_x_in;
   logic [11:0] cursor_y_ff, cursor_y_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] rsp_cell_x_ff, rsp_cell_x_in;
   logic [12:0] rsp_cell_y_ff, rsp_cell_y_in;
   logic [15:0] rsp_cell_color_ff, rsp_cell_color_in;
   logic        rsp_last_cell_ff, rsp_last_cell_in;

   logic [3:0]  size;
   logic [6:0]  advance_x;
   logic [6:0]  advance_y;
   logic        wrap;
   logic [11:0] line_y;
   logic [11:0] base_x;
   logic [11:0] base_y;
   logic [6:0]  glyph_index;
   logic        req_accept;
   logic        is_lf;
   logic        is_cr;
   logic        walk_start;
   logic        walk_advance;
   logic        walk_busy;
   tgcr_pkg::walk_start_type start_data;
   tgcr_pkg::cell_type       walk_cell;

   // Configuration register writes.
   always_comb begin
      fg_color_in = fg_color_ff;
      bg_color_in = bg_color_ff;
      opaque_mode_in = opaque_mode_ff;
      text_size_in = text_size_ff;
      wrap_enable_in = wrap_enable_ff;
      display_width_in = display_width_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            tgcr_pkg::CSR_FG_COLOR:      fg_color_in = csr_wdata;
            tgcr_pkg::CSR_BG_COLOR:      bg_color_in = csr_wdata;
            tgcr_pkg::CSR_OPAQUE_MODE:   opaque_mode_in = csr_wdata[0];
            tgcr_pkg::CSR_TEXT_SIZE:     text_size_in = csr_wdata[3:0];
            tgcr_pkg::CSR_WRAP_ENABLE:   wrap_enable_in = csr_wdata[0];
            tgcr_pkg::CSR_DISPLAY_WIDTH: display_width_in = csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_color_ff <= 16'hFFFF;
         bg_color_ff <= 16'h0000;
         opaque_mode_ff <= 1'b0;
         text_size_ff <= 4'd1;
         wrap_enable_ff <= 1'b1;
         display_width_ff <= 12'd240;
      end else begin
         fg_color_ff <= fg_color_in;
         bg_color_ff <= bg_color_in;
         opaque_mode_ff <= opaque_mode_in;
         text_size_ff <= text_size_in;
         wrap_enable_ff <= wrap_enable_in;
         display_width_ff <= display_width_in;
      end
   end

   // Glyph pitch and line pitch; a size of zero counts as one.
   assign size = (text_size_ff == 4'd0) ? 4'd1 : text_size_ff;
   assign advance_x = 7'({size, 2'b00}) + 7'({size, 1'b0});
   assign advance_y = 7'({size, 3'b000});

   // Wrap decision and the glyph origin after it.
   assign wrap = wrap_enable_ff &&
                 ((13'(cursor_x_ff) + 13'(advance_x)) > 13'(display_width_ff));
   assign line_y = tgcr_pkg::sat_coord(13'(cursor_y_ff) + 13'(advance_y));
   assign base_x = wrap ? 12'd0 : cursor_x_ff;
   assign base_y = wrap ? line_y : cursor_y_ff;

   // Unprintable codes fall back to the question mark.
   always_comb begin
      if ((req_char_code < tgcr_pkg::CHAR_FIRST) || (req_char_code > tgcr_pkg::CHAR_LAST)) begin
         glyph_index = 7'(tgcr_pkg::CHAR_QUESTION - tgcr_pkg::CHAR_FIRST);
      end else begin
         glyph_index = 7'(req_char_code - tgcr_pkg::CHAR_FIRST);
      end
   end

   assign req_ready = !walk_busy;
   assign req_accept = req_valid && req_ready;
   assign is_lf = (req_char_code == tgcr_pkg::CHAR_LF);
   assign is_cr = (req_char_code == tgcr_pkg::CHAR_CR);
   assign walk_start = req_accept && (req_op == tgcr_pkg::OP_CHAR) && !is_lf && !is_cr;

   assign start_data.glyph = tgcr_pkg::GLYPH_ROM[glyph_index];
   assign start_data.x = base_x;
   assign start_data.y = base_y;

   // Cursor update for each accepted transaction.
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (req_accept) begin
         if (req_op == tgcr_pkg::OP_CURSOR) begin
            cursor_x_in = tgcr_pkg::sat_coord(13'(req_new_x));
            cursor_y_in = tgcr_pkg::sat_coord(13'(req_new_y));
         end else if (is_lf) begin
            cursor_x_in = 12'd0;
            cursor_y_in = line_y;
         end else if (!is_cr) begin
            cursor_x_in = tgcr_pkg::sat_coord(13'(base_x) + 13'(advance_x));
            cursor_y_in = base_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= 12'd0;
         cursor_y_ff <= 12'd0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
      end
   end

   tgcr_glyph_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .start      (walk_start),
      .start_data (start_data),
      .size       (size),
      .opaque     (opaque_mode_ff),
      .advance    (walk_advance),
      .busy       (walk_busy),
      .walk_cell  (walk_cell)
   );

   // The walker steps whenever the response register is free or being emptied.
   assign walk_advance = !rsp_valid_ff || rsp_ready;

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_x_in = rsp_cell_x_ff;
      rsp_cell_y_in = rsp_cell_y_ff;
      rsp_cell_color_in = rsp_cell_color_ff;
      rsp_last_cell_in = rsp_last_cell_ff;
      if (walk_advance && walk_cell.emit) begin
         rsp_valid_in = 1'b1;
         rsp_cell_x_in = walk_cell.x;
         rsp_cell_y_in = walk_cell.y;
         rsp_cell_color_in = walk_cell.lit ? fg_color_ff : bg_color_ff;
         rsp_last_cell_in = walk_cell.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_x_ff <= rsp_cell_x_in;
      rsp_cell_y_ff <= rsp_cell_y_in;
      rsp_cell_color_ff <= rsp_cell_color_in;
      rsp_last_cell_ff <= rsp_last_cell_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_x = rsp_cell_x_ff;
   assign rsp_cell_y = rsp_cell_y_ff;
   assign rsp_cell_color = rsp_cell_color_ff;
   assign rsp_last_cell = rsp_last_cell_ff;

endmodule

/* hw/rtl/tgcr_checker.sv */
`include "text_glyph_cell_renderer_macros.svh"

// Port-level checks of the glyph renderer.
module tgcr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_op,
   input logic [7:0]  req_char_code,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [12:0] rsp_cell_x,
   input logic [12:0] rsp_cell_y,
   input logic [15:0] rsp_cell_color,
   input logic        rsp_last_cell,
   input logic        csr_write_enable
);

   logic        char_accept;
   logic        cursor_accept;
   logic        rsp_stall;
   logic        block_idle;
   logic [42:0] rsp_payload;

   assign char_accept = req_valid && req_ready && (req_op == tgcr_pkg::OP_CHAR) &&
                        (req_char_code != tgcr_pkg::CHAR_LF) &&
                        (req_char_code != tgcr_pkg::CHAR_CR);
   assign cursor_accept = req_valid && req_ready && (req_op == tgcr_pkg::OP_CURSOR);
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign block_idle = req_ready && !rsp_valid;
   assign rsp_payload = {rsp_cell_x, rsp_cell_y, rsp_cell_color, rsp_last_cell};

   // A stalled cell holds its payload.
   `TGCR_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled cell changed")

   // A character other than newline or carriage return occupies the block while its cells are walked.
   `TGCR_ASSERT_NEXT(a_char_busy, char_accept, !req_ready, "request taken during glyph walk")

   // A cursor set finishes in the cycle it is accepted.
   `TGCR_ASSERT_NEXT(a_cursor_quick, cursor_accept, req_ready, "cursor set blocked the input")

   // Registers are written only while no character is in progress.
   `TGCR_ASSERT(a_cfg_idle, !csr_write_enable || block_idle, "register write while busy")

   // Handshake outputs are never unknown.
   `TGCR_ASSERT(a_handshake_known, !$isunknown({req_ready, rsp_valid}), "handshake output unknown")

endmodule

bind text_glyph_cell_renderer tgcr_checker u_tgcr_checker (.*);

/* tb/testbench.sv */
import tgcr_pkg::*;

module testbench;

   // Column bitmaps of the printable glyphs 0x20..0x7E, column 0 in the top byte,
   // bit 0 of each byte as the top row.
   localparam logic [39:0] FONT_COLUMNS [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
      40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0008142241, 40'h1414141414,
      40'h4122140800, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h7F2018207F, 40'h6314081463, 40'h0304780403, 40'h6151494543, 40'h00007F4141,
      40'h0204081020, 40'h41417F0000, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h081454543C, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008
   };

   // Cycles a glyph walk may still be running after its last cell has gone out.
   localparam int DRAIN_CYCLES = 64;

   typedef struct {
      logic [12:0] x;
      logic [12:0] y;
      logic [15:0] color;
      logic last;
   } glyph_cell_t;

   typedef struct {
      logic [15:0] fg;
      logic [15:0] bg;
      logic opaque;
      logic [3:0] size;
      logic wrap;
      logic [11:0] width;
   } render_settings_t;

   // Tracks the cursor and register state and keeps the cells still owed by the block.
   class glyph_scoreboard;
      logic [15:0] fg;
      logic [15:0] bg;
      logic opaque;
      logic [3:0] size;
      logic wrap;
      logic [11:0] width;
      int unsigned cur_x;
      int unsigned cur_y;
      glyph_cell_t expected_cells[$];
      int failures;

      function new();
         fg = 16'hFFFF;
         bg = 16'h0000;
         opaque = 1'b0;
         size = 4'd1;
         wrap = 1'b1;
         width = 12'd240;
         cur_x = 0;
         cur_y = 0;
         failures = 0;
      endfunction

      function int unsigned clamp(int unsigned v);
         return (v > COORD_MAX) ? COORD_MAX : v;
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction

      function void write_register(logic [2:0] index, logic [15:0] value);
         case (index)
            CSR_FG_COLOR: fg = value;
            CSR_BG_COLOR: bg = value;
            CSR_OPAQUE_MODE: opaque = value[0];
            CSR_TEXT_SIZE: size = value[3:0];
            CSR_WRAP_ENABLE: wrap = value[0];
            CSR_DISPLAY_WIDTH: width = value[11:0];
            default: ;
         endcase
      endfunction

      // Updates the cursor for one accepted request and queues the cells it draws.
      function void note_request(logic op, logic [7:0] code, logic [11:0] nx, logic [11:0] ny);
         int unsigned scale;
         int unsigned idx;
         logic [7:0] glyph;
         logic [7:0] bits;
         logic lit;
         glyph_cell_t held;
         bit have_held;
         scale = (size == 4'd0) ? 1 : size;
         have_held = 0;
         if (op == OP_CURSOR) begin
            cur_x = clamp(nx);
            cur_y = clamp(ny);
            return;
         end
         if (code == CHAR_LF) begin
            cur_x = 0;
            cur_y = clamp(cur_y + 8 * scale);
            return;
         end
         if (code == CHAR_CR)
            return;
         if (wrap && cur_x + 6 * scale > width) begin
            cur_x = 0;
            cur_y = clamp(cur_y + 8 * scale);
         end
         glyph = (code < CHAR_FIRST || code > CHAR_LAST) ? CHAR_QUESTION : code;
         idx = glyph - CHAR_FIRST;
         for (int col = 0; col < 6; col++) begin
            bits = (col < 5) ? 8'(FONT_COLUMNS[idx] >> (32 - 8 * col)) : 8'h00;
            for (int row = 0; row < 8; row++) begin
               lit = bits[row];
               if (!lit && !opaque)
                  continue;
               if (have_held)
                  expected_cells.push_back(held);
               held.x = 13'(cur_x + col * scale);
               held.y = 13'(cur_y + row * scale);
               held.color = lit ? fg : bg;
               held.last = 1'b0;
               have_held = 1;
            end
         end
         // The final cell of the character carries the last flag.
         if (have_held) begin
            held.last = 1'b1;
            expected_cells.push_back(held);
         end
         cur_x = clamp(cur_x + 6 * scale);
      endfunction

      // Compares one cell leaving the block with the oldest one owed.
      function void check_cell(logic [12:0] x, logic [12:0] y, logic [15:0] color,
                               logic last);
         glyph_cell_t want;
         if (expected_cells.size() == 0) begin
            $display("%0t: unexpected cell x=%0d y=%0d color=%h last=%b",
                     $time, x, y, color, last);
            failures++;
            return;
         end
         want = expected_cells.pop_front();
         if (x !== want.x) begin
            $display("%0t: cell_x expected %0d, actual %0d", $time, want.x, x);
            failures++;
         end
         if (y !== want.y) begin
            $display("%0t: cell_y expected %0d, actual %0d", $time, want.y, y);
            failures++;
         end
         if (color !== want.color) begin
            $display("%0t: cell_color expected %h, actual %h", $time, want.color, color);
            failures++;
         end
         if (last !== want.last) begin
            $display("%0t: last_cell expected %b, actual %b", $time, want.last, last);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = 1'b0;
   logic [7:0] req_char_code = 8'h00;
   logic [11:0] req_new_x = 12'd0;
   logic [11:0] req_new_y = 12'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [12:0] rsp_cell_x;
   logic [12:0] rsp_cell_y;
   logic [15:0] rsp_cell_color;
   logic rsp_last_cell;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = 3'd0;
   logic [15:0] csr_wdata = 16'h0000;

   bit steady = 0;
   int unsigned rsp_hold = 0;
   glyph_scoreboard board = new();

   text_glyph_cell_renderer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_char_code(req_char_code),
      .req_new_x(req_new_x),
      .req_new_y(req_new_y),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell_x(rsp_cell_x),
      .rsp_cell_y(rsp_cell_y),
      .rsp_cell_color(rsp_cell_color),
      .rsp_last_cell(rsp_last_cell),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Idle length between transactions: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Response side back-pressure, after transactions and at random while waiting.
   always @(posedge clock) begin : rsp_pacing
      int pick;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (rsp_valid && rsp_ready) begin
         pick = pick_gap();
         rsp_hold <= pick;
         rsp_ready <= (pick == 0);
      end else begin
         rsp_ready <= steady || ($urandom_range(0, 9) != 0);
      end
   end

   // Every accepted response transaction is checked against the oldest expected cell.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_cell(rsp_cell_x, rsp_cell_y, rsp_cell_color, rsp_last_cell);
   end

   // Presents one request and returns at the edge that accepts it, valid still high.
   task automatic send_request(input logic op, input logic [7:0] code,
                               input logic [11:0] nx, input logic [11:0] ny);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_char_code <= code;
      req_new_x <= nx;
      req_new_y <= ny;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(op, code, nx, ny);
   endtask

   task automatic send_char(input logic [7:0] code);
      send_request(OP_CHAR, code, 12'($urandom), 12'($urandom));
   endtask

   task automatic send_cursor(input logic [11:0] nx, input logic [11:0] ny);
      send_request(OP_CURSOR, 8'($urandom), nx, ny);
   endtask

   // Drops valid and waits until every owed cell is out and the walker has finished.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes all six registers on consecutive edges; the block must be idle.
   task automatic apply_settings(input render_settings_t cfg);
      logic [2:0] regs [6];
      logic [15:0] values [6];
      regs = '{CSR_FG_COLOR, CSR_BG_COLOR, CSR_OPAQUE_MODE, CSR_TEXT_SIZE,
               CSR_WRAP_ENABLE, CSR_DISPLAY_WIDTH};
      values = '{cfg.fg, cfg.bg, 16'(cfg.opaque), 16'(cfg.size), 16'(cfg.wrap),
                 16'(cfg.width)};
      for (int i = 0; i < 6; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= values[i];
         board.write_register(regs[i], values[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   function automatic render_settings_t phase_settings(int phase);
      render_settings_t cfg;
      cfg.fg = 16'($urandom);
      cfg.bg = 16'($urandom);
      cfg.opaque = 1'($urandom);
      cfg.size = 4'($urandom_range(0, 15));
      cfg.wrap = 1'($urandom);
      cfg.width = 12'($urandom);
      case (phase)
         1: cfg = '{16'h0000, 16'hFFFF, 1'b1, 4'd15, 1'b0, 12'd0};
         2: cfg = '{16'hF800, 16'h07E0, 1'b1, 4'd0, 1'b1, 12'd0};
         3: cfg = '{cfg.fg, cfg.bg, 1'b0, 4'd8, 1'b1, 12'd4095};
         4: cfg = '{cfg.fg, cfg.bg, 1'b1, 4'd1, 1'b1, 12'd1};
         default: ;
      endcase
      return cfg;
   endfunction

   // Edge cases at the reset settings: glyph range limits, substitution, control codes,
   // wrapping right at the width, and a saturated cursor.
   task automatic run_directed();
      send_char(8'h41);
      send_char(CHAR_FIRST);
      send_char(CHAR_LAST);
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h7F);
      send_char(8'h1F);
      send_char(CHAR_CR);
      send_char(CHAR_LF);
      send_char(CHAR_QUESTION);
      send_cursor(12'd234, 12'd20);
      send_char(8'h23);
      send_char(8'h24);
      send_cursor(12'd4095, 12'd4095);
      send_char(8'h57);
      send_char(8'h40);
      send_cursor(12'd4095, 12'd4095);
      send_char(CHAR_LF);
      send_cursor(12'd0, 12'd0);
   endtask

   // Largest scale with wrapping off: cells run past the cursor range.
   task automatic run_extremes();
      send_cursor(12'd4095, 12'd4095);
      send_char(CHAR_LAST);
      send_char(CHAR_FIRST);
      send_char(CHAR_LF);
      send_cursor(12'd0, 12'd0);
   endtask

   // Mostly printable text with newlines and cursor moves, plus arbitrary bytes.
   task automatic run_random(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 62)
            send_char(8'($urandom_range(CHAR_FIRST, CHAR_LAST)));
         else if (r < 74)
            send_char(8'($urandom));
         else if (r < 82)
            send_char(CHAR_LF);
         else if (r < 86)
            send_char(CHAR_CR);
         else if (r < 93)
            send_cursor(12'($urandom_range(0, 300)), 12'($urandom_range(0, 300)));
         else
            send_cursor(12'($urandom), 12'($urandom));
      end
   endtask

   initial begin : stimulus
      render_settings_t cfg;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(36);
      settle();
      for (int phase = 1; phase < 8; phase++) begin
         cfg = phase_settings(phase);
         steady = (phase == 3);
         apply_settings(cfg);
         if (phase == 1)
            run_extremes();
         run_random(36);
         settle();
      end
      if (board.failures == 0 && board.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end

endmodule
